### rtl/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

  // Frame layout
  localparam logic [7:0] SYNC_FIRST   = 8'h24;
  localparam logic [7:0] SYNC_SECOND  = 8'h14;
  localparam logic [7:0] CHECK_MASK   = 8'hFE;
  localparam int         HEADER_BYTES = 6;

  // Command slot register layout
  localparam int SLOT_REGS   = 8;
  localparam int SLOT_W      = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int SLOT_LEN_W  = 6;
  localparam int SLOT_LEN_LO = 8;
  localparam int SLOT_EN_BIT = 14;

  // Parameter defaults
  localparam int PAYLOAD_MAX_DEF   = 32;
  localparam int COMMAND_SLOTS_DEF = 8;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_LEN,
    ST_CMD,
    ST_CHK1,
    ST_CHK2,
    ST_PAYLOAD
  } rx_state_t;

  // One accepted frame, handed from parser to emitter
  typedef struct packed {
    logic [7:0]            cmd;
    logic [SLOT_LEN_W-1:0] len;
    logic                  bank;
  } frame_desc_t;

  // Emitter to queue
  typedef struct packed {
    logic take;  // head descriptor consumed
    logic done;  // last item of a frame delivered, bank free
  } bk_ctl_t;

  // Queue status
  typedef struct packed {
    logic       hd_valid;
    logic       full;   // both payload banks held
    logic [1:0] busy;   // frames accepted, not yet fully delivered
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/framed_packet_receiver_top.sv
// Channel   | Valid        | Stall        | Payload
// ----------+--------------+--------------+--------------------------------------------
// rx in     | rx_valid     | rx_stall     | rx_byte
// frame out | frame_valid  | frame_stall  | frame_command, payload_byte, has_payload,
//           |              |              | last_of_frame
// config    | cfg_we       | (none)       | cfg_index, cfg_data
//
// One rx item per cycle while rx_stall is low; results leave at one item per
// cycle while frame_stall is low. The first result of a frame passes, after its final
// byte, through the queue, current-frame register, RAM read and output register.
// rx_stall rises only while two accepted frames still await delivery: both
// halves of the double-buffered payload RAM are then held.
// rst is synchronous, active high; slot registers clear to disabled.
`default_nettype none

module framed_packet_receiver_top #(
  parameter int PAYLOAD_MAX   = fpr_pkg::PAYLOAD_MAX_DEF,
  parameter int COMMAND_SLOTS = fpr_pkg::COMMAND_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fpr_pkg::SLOT_W-1:0]       cfg_data,
  input  wire logic                             rx_valid,
  output logic                                  rx_stall,
  input  wire logic [7:0]                       rx_byte,
  output logic                                  frame_valid,
  input  wire logic                             frame_stall,
  output logic      [7:0]                       frame_command,
  output logic      [7:0]                       payload_byte,
  output logic                                  has_payload,
  output logic                                  last_of_frame
);

  // Payload RAM: two banks of 2^IDX_W bytes, bank bit on top of the address
  localparam int IDX_W     = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

  logic                 ram_we;
  logic [IDX_W:0]       ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [IDX_W:0]       ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 push;
  fpr_pkg::frame_desc_t desc;
  fpr_pkg::frame_desc_t head;
  fpr_pkg::q_stat_t     stat;
  fpr_pkg::bk_ctl_t     ctl;

  // Front: frame parser, slot match and check; writes payload into its bank
  fpr_front #(
    .PAYLOAD_MAX   (PAYLOAD_MAX),
    .COMMAND_SLOTS (COMMAND_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .desc      (desc)
  );

  fpr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Descriptors of checked frames; also counts banks in use
  fpr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .desc_in (desc),
    .ctl     (ctl),
    .head    (head),
    .stat    (stat)
  );

  // Back: walks each frame's bank; one item per payload byte, one bare item if empty
  fpr_back #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (stat),
    .ctl           (ctl),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .frame_command (frame_command),
    .payload_byte  (payload_byte),
    .has_payload   (has_payload),
    .last_of_frame (last_of_frame)
  );

  assign rx_stall = stat.full;

`ifndef SYNTHESIS
  // A push lands only while a bank is free
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("frame pushed with both banks held");

  // A descriptor is taken only for a frame still counted as outstanding
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> stat.busy != 2'd0)
    else $error("descriptor taken with no frame outstanding");

  // An item without payload is always the whole frame
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !has_payload |-> last_of_frame)
    else $error("payload-less item not marked last");
`endif

endmodule

`default_nettype wire

### rtl/fpr_ram.sv
`default_nettype none

module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/fpr_front.sv
`default_nettype none

module fpr_front #(
  parameter int PAYLOAD_MAX   = fpr_pkg::PAYLOAD_MAX_DEF,
  parameter int COMMAND_SLOTS = fpr_pkg::COMMAND_SLOTS_DEF,
  localparam int IDX_W        = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fpr_pkg::SLOT_W-1:0]       cfg_data,
  input  wire logic                             rx_valid,
  input  wire logic                             rx_stall,
  input  wire logic [7:0]                       rx_byte,
  output logic                                  ram_we,
  output logic      [IDX_W:0]                   ram_waddr,
  output logic      [7:0]                       ram_wdata,
  output logic                                  push,
  output fpr_pkg::frame_desc_t                  desc
);

  localparam int LW = fpr_pkg::SLOT_LEN_W;

  logic [fpr_pkg::SLOT_W-1:0] slot [COMMAND_SLOTS];

  fpr_pkg::rx_state_t state, state_next;
  logic [7:0]    flen;
  logic [7:0]    fcmd;
  logic [LW-1:0] exp_len;
  logic [7:0]    chk1;
  logic [7:0]    chk2;
  logic [7:0]    rxor;
  logic [LW-1:0] pidx;
  logic          wr_bank;

  logic          accept;
  logic          hit;
  logic [LW-1:0] hit_len;
  logic [7:0]    xor_new;

  function automatic logic check_ok(input logic [7:0] x, input logic [7:0] c1,
                                    input logic [7:0] c2);
    logic [7:0] m;
    m = x & fpr_pkg::CHECK_MASK;
    return (c1 == m) && (c2 == (~m & fpr_pkg::CHECK_MASK));
  endfunction

  for (genvar s = 0; s < COMMAND_SLOTS; s++) begin : g_slot
    always_ff @(posedge clk) begin
      if (rst) begin
        slot[s] <= '0;
      end else if (cfg_we && cfg_index == fpr_pkg::CFG_INDEX_W'(s)) begin
        slot[s] <= cfg_data;
      end
    end
  end

  // Parallel slot compare, lowest slot wins
  always_comb begin
    logic [LW-1:0] n;
    hit     = 1'b0;
    hit_len = '0;
    for (int s = COMMAND_SLOTS - 1; s >= 0; s--) begin
      n = slot[s][fpr_pkg::SLOT_LEN_LO +: LW];
      if (slot[s][fpr_pkg::SLOT_EN_BIT] && slot[s][7:0] == rx_byte &&
          n <= LW'(PAYLOAD_MAX) &&
          flen == 8'(fpr_pkg::HEADER_BYTES) + 8'(n)) begin
        hit     = 1'b1;
        hit_len = n;
      end
    end
  end

  assign accept  = rx_valid && !rx_stall;
  assign xor_new = rxor ^ rx_byte;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    push       = 1'b0;
    if (accept) begin
      unique case (state)
        fpr_pkg::ST_HUNT: begin
          if (rx_byte == fpr_pkg::SYNC_FIRST) state_next = fpr_pkg::ST_SYNC2;
        end
        fpr_pkg::ST_SYNC2: begin
          state_next = (rx_byte == fpr_pkg::SYNC_SECOND) ? fpr_pkg::ST_LEN
                                                         : fpr_pkg::ST_HUNT;
        end
        fpr_pkg::ST_LEN: begin
          state_next = fpr_pkg::ST_CMD;
        end
        fpr_pkg::ST_CMD: begin
          state_next = hit ? fpr_pkg::ST_CHK1 : fpr_pkg::ST_HUNT;
        end
        fpr_pkg::ST_CHK1: begin
          state_next = fpr_pkg::ST_CHK2;
        end
        fpr_pkg::ST_CHK2: begin
          if (exp_len == '0) begin
            state_next = fpr_pkg::ST_HUNT;
            push       = check_ok(rxor, chk1, rx_byte);
          end else begin
            state_next = fpr_pkg::ST_PAYLOAD;
          end
        end
        fpr_pkg::ST_PAYLOAD: begin
          ram_we = 1'b1;
          if (pidx + LW'(1) == exp_len) begin
            state_next = fpr_pkg::ST_HUNT;
            push       = check_ok(xor_new, chk1, chk2);
          end
        end
        default: state_next = fpr_pkg::ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fpr_pkg::ST_HUNT;
      wr_bank <= 1'b0;
    end else begin
      state <= state_next;
      if (push) wr_bank <= ~wr_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (state)
        fpr_pkg::ST_LEN: begin
          flen <= rx_byte;
          rxor <= rx_byte;
        end
        fpr_pkg::ST_CMD: begin
          fcmd    <= rx_byte;
          exp_len <= hit_len;
          rxor    <= xor_new;
        end
        fpr_pkg::ST_CHK1: chk1 <= rx_byte;
        fpr_pkg::ST_CHK2: begin
          chk2 <= rx_byte;
          pidx <= '0;
        end
        fpr_pkg::ST_PAYLOAD: begin
          rxor <= xor_new;
          pidx <= pidx + LW'(1);
        end
        default: ;
      endcase
    end
  end

  assign ram_waddr = {wr_bank, pidx[IDX_W-1:0]};
  assign ram_wdata = rx_byte;
  assign desc.cmd  = fcmd;
  assign desc.len  = exp_len;
  assign desc.bank = wr_bank;

endmodule

`default_nettype wire

### rtl/fpr_queue.sv
`default_nettype none

module fpr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  fpr_pkg::frame_desc_t      desc_in,
  input  fpr_pkg::bk_ctl_t          ctl,
  output fpr_pkg::frame_desc_t      head,
  output fpr_pkg::q_stat_t          stat
);

  fpr_pkg::frame_desc_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] busy;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= desc_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      busy   <= '0;
    end else begin
      if (push)     wr_ptr <= ~wr_ptr;
      if (ctl.take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(ctl.take);
      busy  <= busy + 2'(push) - 2'(ctl.done);
    end
  end

  assign head          = entry[rd_ptr];
  assign stat.hd_valid = (count != '0);
  assign stat.full     = (busy == 2'd2);
  assign stat.busy     = busy;

endmodule

`default_nettype wire

### rtl/fpr_back.sv
`default_nettype none

module fpr_back #(
  parameter int PAYLOAD_MAX = fpr_pkg::PAYLOAD_MAX_DEF,
  localparam int IDX_W      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  fpr_pkg::frame_desc_t  head,
  input  fpr_pkg::q_stat_t      stat,
  output fpr_pkg::bk_ctl_t      ctl,
  output logic                  ram_re,
  output logic      [IDX_W:0]   ram_raddr,
  input  wire logic [7:0]       ram_rdata,
  output logic                  frame_valid,
  input  wire logic             frame_stall,
  output logic      [7:0]       frame_command,
  output logic      [7:0]       payload_byte,
  output logic                  has_payload,
  output logic                  last_of_frame
);

  localparam int LW = fpr_pkg::SLOT_LEN_W;

  // Frame being walked
  logic          cur_valid;
  logic [7:0]    cur_cmd;
  logic [LW-1:0] cur_len;
  logic          cur_bank;
  logic [LW-1:0] cnt;

  // Read stage: RAM data lands alongside these
  logic       p1_valid;
  logic [7:0] p1_cmd;
  logic       p1_has;
  logic       p1_last;

  logic issue, issue_last, adv1, load, out_take;

  assign out_take   = frame_valid && !frame_stall;
  assign adv1       = p1_valid && (!frame_valid || !frame_stall);
  assign issue      = cur_valid && (!p1_valid || adv1);
  assign issue_last = (cur_len == '0) || (cnt + LW'(1) == cur_len);
  assign load       = stat.hd_valid && (!cur_valid || (issue && issue_last));

  assign ctl.take  = load;
  assign ctl.done  = out_take && last_of_frame;
  assign ram_re    = issue && (cur_len != '0);
  assign ram_raddr = {cur_bank, cnt[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      p1_valid    <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (load)                     cur_valid <= 1'b1;
      else if (issue && issue_last) cur_valid <= 1'b0;
      if (issue)     p1_valid <= 1'b1;
      else if (adv1) p1_valid <= 1'b0;
      if (adv1)          frame_valid <= 1'b1;
      else if (out_take) frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_cmd  <= head.cmd;
      cur_len  <= head.len;
      cur_bank <= head.bank;
      cnt      <= '0;
    end else if (issue) begin
      cnt <= cnt + LW'(1);
    end
    if (issue) begin
      p1_cmd  <= cur_cmd;
      p1_has  <= (cur_len != '0);
      p1_last <= issue_last;
    end
    if (adv1) begin
      frame_command <= p1_cmd;
      payload_byte  <= p1_has ? ram_rdata : 8'h00;
      has_payload   <= p1_has;
      last_of_frame <= p1_last;
    end
  end

endmodule

`default_nettype wire
